[hw/rtl/awfn_pkg.sv]
package awfn_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;

  localparam int POS_W = 48;
  localparam int OUT_W = 40;

  localparam int D_W  = COORD_BITS + 1;
  localparam int P_W  = 2 * D_W;
  localparam int C_W  = P_W + 1;
  localparam int M_W  = P_W;
  localparam int NC_W = 2 * M_W + 2;
  localparam int PE_W = $clog2(M_W);

  localparam int AREA_T  = 15 - 2 * FRAC_BITS;
  localparam int SQ_SHL  = (AREA_T >= 0) ? 2 * (AREA_T + 1) : 0;
  localparam int SQ_SHR  = (AREA_T < 0) ? -AREA_T - 1 : 0;
  localparam int SQ_RAW  = (NC_W + SQ_SHL > 64) ? NC_W + SQ_SHL : 64;
  localparam int SQ_IN_W = SQ_RAW + SQ_RAW % 2;
  localparam int SQ_R_W  = SQ_IN_W / 2;
  localparam int A_W     = SQ_R_W;

  localparam int DN_W  = 30;
  localparam int LEN_W = 32;
  localparam int DEN_W = LEN_W + 1;
  localparam int Q_W   = 32;
  localparam int NUM_W = DN_W + Q_W + 1;

  localparam int AH_W = A_W / 2;
  localparam int AL_W = A_W - AH_W;
  localparam int PR_W = Q_W + A_W;
  localparam int R_W  = PR_W + 1 - 30;
  localparam int RX_W = (R_W > OUT_W + 1) ? R_W : OUT_W + 1;

  typedef logic [DN_W-1:0] dn_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         neg;
    logic               degen;
    dn_t [2:0]          dn;
    logic [SQ_IN_W-1:0] area_sq;
    logic [SQ_IN_W-1:0] len_sq;
  } front_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
    dn_t [2:0]  dn;
  } sq_side_t;

  typedef struct packed {
    logic [2:0]     neg;
    logic           degen;
    logic [A_W-1:0] area;
  } div_side_t;

endpackage

[hw/rtl/area_weighted_face_normal.sv]
// channel  signals                                  dir  word
// in       in_valid, in_stall, mode, ori_p0..cur_p2  in   one triangle, six packed positions
// out      out_valid, out_stall, norm_x/y/z, degen.  out  weighted normal, degenerate flag
//
// one word per cycle sustained while in_stall is low; pipeline: 9 front stages, one sqrt
// stage per root bit, one mid stage, one divider stage per quotient bit, 2 back stages
// rst is synchronous and clears every valid bit; payload registers are not reset
// the whole pipeline advances together whenever the output register is empty or taken
// in_stall follows out_valid and out_stall in the same cycle
module area_weighted_face_normal import awfn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    mode,
  input  logic [POS_W-1:0]        ori_p0,
  input  logic [POS_W-1:0]        ori_p1,
  input  logic [POS_W-1:0]        ori_p2,
  input  logic [POS_W-1:0]        cur_p0,
  input  logic [POS_W-1:0]        cur_p1,
  input  logic [POS_W-1:0]        cur_p2,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] norm_x,
  output logic signed [OUT_W-1:0] norm_y,
  output logic signed [OUT_W-1:0] norm_z,
  output logic                    degenerate
);

  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(64'd1 << DN_W);
  localparam logic [Q_W-1:0]   U_MAX   = Q_W'(64'd1 << (DN_W + 1));

  logic en;
  front_t fr;
  logic [SQ_R_W-1:0] area_root, len_root;
  sq_side_t sq_in;
  sq_side_t sqd [SQ_R_W];
  logic [SQ_R_W-1:0] sqv;

  logic mid_vld;
  div_side_t mid_side;
  logic [NUM_W-1:0] mid_num [3];
  logic [DEN_W-1:0] mid_den;
  logic [A_W:0] area_n;
  logic [LEN_W-1:0] len;

  div_side_t dvd [Q_W];
  logic [Q_W-1:0] dvv;
  logic [2:0][Q_W-1:0] quo;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  awfn_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .mode(mode),
    .ori_p0(ori_p0), .ori_p1(ori_p1), .ori_p2(ori_p2),
    .cur_p0(cur_p0), .cur_p1(cur_p1), .cur_p2(cur_p2), .fr(fr)
  );

  awfn_sqrt u_sqrt_area (.clk(clk), .en(en), .x(fr.area_sq), .root(area_root));
  awfn_sqrt u_sqrt_len  (.clk(clk), .en(en), .x(fr.len_sq),  .root(len_root));

  assign sq_in = '{neg: fr.neg, degen: fr.degen, dn: fr.dn};

  always_ff @(posedge clk) begin
    if (rst) begin
      sqv     <= '0;
      mid_vld <= 1'b0;
      dvv     <= '0;
    end else if (en) begin
      sqv     <= {sqv[SQ_R_W-2:0], fr.valid};
      mid_vld <= sqv[SQ_R_W-1];
      dvv     <= {dvv[Q_W-2:0], mid_vld};
    end
  end

  always_comb begin
    area_n = (A_W+1)'(area_root >> SQ_SHR) + (A_W+1)'(1);
    len    = len_root[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqd[0] <= sq_in;
      for (int i = 1; i < SQ_R_W; i++) sqd[i] <= sqd[i-1];

      mid_side.neg   <= sqd[SQ_R_W-1].neg;
      mid_side.degen <= sqd[SQ_R_W-1].degen;
      mid_side.area  <= area_n[A_W:1];
      mid_den        <= {len, 1'b0};
      for (int k = 0; k < 3; k++) begin
        mid_num[k] <= NUM_W'({sqd[SQ_R_W-1].dn[k], {Q_W{1'b0}}}) + NUM_W'(len);
      end

      dvd[0] <= mid_side;
      for (int i = 1; i < Q_W; i++) dvd[i] <= dvd[i-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    awfn_div u_div (
      .clk(clk), .en(en), .num(mid_num[k]), .den(mid_den), .quo(quo[k])
    );
  end

  awfn_back u_back (
    .clk(clk), .rst(rst), .en(en), .in_vld(dvv[Q_W-1]), .side(dvd[Q_W-1]), .quo(quo),
    .out_valid(out_valid), .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .degenerate(degenerate)
  );

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> norm_x == '0 && norm_y == '0 && norm_z == '0)
    else $error("degenerate word with nonzero normal");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    sqv[SQ_R_W-1] && !sqd[SQ_R_W-1].degen |-> len >= LEN_MIN)
    else $error("normalized length below range");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    dvv[Q_W-1] && !dvd[Q_W-1].degen |-> quo[0] < U_MAX && quo[1] < U_MAX && quo[2] < U_MAX)
    else $error("unit component out of range");

endmodule

[hw/rtl/awfn_front.sv]
module awfn_front import awfn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic             mode,
  input  logic [POS_W-1:0] ori_p0,
  input  logic [POS_W-1:0] ori_p1,
  input  logic [POS_W-1:0] ori_p2,
  input  logic [POS_W-1:0] cur_p0,
  input  logic [POS_W-1:0] cur_p1,
  input  logic [POS_W-1:0] cur_p2,
  output front_t           fr
);

  function automatic logic signed [D_W-1:0] sx(input logic [POS_W-1:0] p, input int k);
    logic signed [COORD_BITS-1:0] c;
    c = $signed(p[k*COORD_BITS +: COORD_BITS]);
    return D_W'(c);
  endfunction

  function automatic logic [M_W-1:0] mag_of(input logic signed [C_W-1:0] v);
    logic [C_W-1:0] a;
    a = v[C_W-1] ? C_W'(-v) : C_W'(v);
    return a[M_W-1:0];
  endfunction

  function automatic logic [PE_W-1:0] lead_pos(input logic [M_W-1:0] v);
    logic [PE_W-1:0] p;
    p = '0;
    for (int i = 0; i < M_W; i++) begin
      if (v[i]) p = PE_W'(i);
    end
    return p;
  endfunction

  function automatic dn_t norm_dn(input logic [M_W-1:0] v, input logic [PE_W-1:0] p);
    logic [M_W+DN_W-1:0] ext;
    ext = (M_W+DN_W)'(v);
    if (int'(p) >= DN_W - 1) ext = ext >> (int'(p) - (DN_W - 1));
    else ext = ext << ((DN_W - 1) - int'(p));
    return ext[DN_W-1:0];
  endfunction

  logic [8:0] vld;

  logic [POS_W-1:0] o0, o1, o2, c0, c1, c2;
  logic mode1, mode2, mode3;
  logic signed [D_W-1:0] ce [3];
  logic signed [D_W-1:0] cf [3];
  logic signed [D_W-1:0] oe [3];
  logic signed [D_W-1:0] of2 [3];
  logic signed [P_W-1:0] cpr [6];
  logic signed [P_W-1:0] opr [6];
  logic signed [C_W-1:0] cc4 [3];
  logic signed [C_W-1:0] dd4 [3];
  logic [M_W-1:0] cm5 [3];
  logic [M_W-1:0] dm5 [3];
  logic [M_W-1:0] mx5;
  logic [2:0] neg5, neg6, neg7, neg8, neg9;
  logic degen5, degen6, degen7, degen8, degen9;
  logic [2*M_W-1:0] csq6 [3];
  logic [M_W-1:0] dm6 [3];
  logic [PE_W-1:0] lp6;
  logic [NC_W-1:0] nc7, nc8;
  dn_t dn7 [3];
  dn_t dn8 [3];
  dn_t dn9 [3];
  logic [2*DN_W-1:0] dsq8 [3];
  logic [SQ_IN_W-1:0] area_sq9, len_sq9;

  logic [M_W-1:0] dmag [3];
  logic [M_W-1:0] mx_c;
  logic [2*DN_W+1:0] nd_c;

  always_comb begin
    for (int k = 0; k < 3; k++) dmag[k] = mag_of(dd4[k]);
    mx_c = dmag[0];
    if (dmag[1] > mx_c) mx_c = dmag[1];
    if (dmag[2] > mx_c) mx_c = dmag[2];
    nd_c = (2*DN_W+2)'(dsq8[0]) + (2*DN_W+2)'(dsq8[1]) + (2*DN_W+2)'(dsq8[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[7:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1 <= mode;
      o0 <= ori_p0; o1 <= ori_p1; o2 <= ori_p2;
      c0 <= cur_p0; c1 <= cur_p1; c2 <= cur_p2;

      mode2 <= mode1;
      for (int k = 0; k < 3; k++) begin
        ce[k]  <= sx(c1, k) - sx(c0, k);
        cf[k]  <= sx(c2, k) - sx(c1, k);
        oe[k]  <= sx(o1, k) - sx(o0, k);
        of2[k] <= sx(o2, k) - sx(o1, k);
      end

      mode3 <= mode2;
      cpr[0] <= P_W'(ce[1]) * P_W'(cf[2]);
      cpr[1] <= P_W'(ce[2]) * P_W'(cf[1]);
      cpr[2] <= P_W'(ce[2]) * P_W'(cf[0]);
      cpr[3] <= P_W'(ce[0]) * P_W'(cf[2]);
      cpr[4] <= P_W'(ce[0]) * P_W'(cf[1]);
      cpr[5] <= P_W'(ce[1]) * P_W'(cf[0]);
      opr[0] <= P_W'(oe[1]) * P_W'(of2[2]);
      opr[1] <= P_W'(oe[2]) * P_W'(of2[1]);
      opr[2] <= P_W'(oe[2]) * P_W'(of2[0]);
      opr[3] <= P_W'(oe[0]) * P_W'(of2[2]);
      opr[4] <= P_W'(oe[0]) * P_W'(of2[1]);
      opr[5] <= P_W'(oe[1]) * P_W'(of2[0]);

      for (int k = 0; k < 3; k++) begin
        cc4[k] <= C_W'(cpr[2*k]) - C_W'(cpr[2*k+1]);
        dd4[k] <= mode3 ? C_W'(cpr[2*k]) - C_W'(cpr[2*k+1])
                        : C_W'(opr[2*k]) - C_W'(opr[2*k+1]);
      end

      for (int k = 0; k < 3; k++) begin
        cm5[k]  <= mag_of(cc4[k]);
        dm5[k]  <= dmag[k];
        neg5[k] <= dd4[k][C_W-1];
      end
      mx5    <= mx_c;
      degen5 <= (dd4[0] == '0) && (dd4[1] == '0) && (dd4[2] == '0);

      for (int k = 0; k < 3; k++) begin
        csq6[k] <= (2*M_W)'(cm5[k]) * (2*M_W)'(cm5[k]);
        dm6[k]  <= dm5[k];
      end
      lp6 <= lead_pos(mx5);
      neg6 <= neg5; degen6 <= degen5;

      nc7 <= NC_W'(csq6[0]) + NC_W'(csq6[1]) + NC_W'(csq6[2]);
      for (int k = 0; k < 3; k++) dn7[k] <= norm_dn(dm6[k], lp6);
      neg7 <= neg6; degen7 <= degen6;

      nc8 <= nc7;
      for (int k = 0; k < 3; k++) begin
        dsq8[k] <= (2*DN_W)'(dn7[k]) * (2*DN_W)'(dn7[k]);
        dn8[k]  <= dn7[k];
      end
      neg8 <= neg7; degen8 <= degen7;

      area_sq9 <= SQ_IN_W'(nc8) << SQ_SHL;
      len_sq9  <= SQ_IN_W'({nd_c, 2'b00});
      for (int k = 0; k < 3; k++) dn9[k] <= dn8[k];
      neg9 <= neg8; degen9 <= degen8;
    end
  end

  assign fr.valid   = vld[8];
  assign fr.neg     = neg9;
  assign fr.degen   = degen9;
  assign fr.dn[0]   = dn9[0];
  assign fr.dn[1]   = dn9[1];
  assign fr.dn[2]   = dn9[2];
  assign fr.area_sq = area_sq9;
  assign fr.len_sq  = len_sq9;

endmodule

[hw/rtl/awfn_sqrt.sv]
module awfn_sqrt import awfn_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [SQ_IN_W-1:0] x,
  output logic [SQ_R_W-1:0]  root
);

  localparam int RM_W = SQ_R_W + 2;

  logic [SQ_R_W-1:0]  rem_q  [SQ_R_W];
  logic [SQ_R_W-1:0]  root_q [SQ_R_W];
  logic [SQ_IN_W-1:0] xs_q   [SQ_R_W];

  logic [SQ_R_W-1:0]  rem_i  [SQ_R_W];
  logic [SQ_R_W-1:0]  root_i [SQ_R_W];
  logic [SQ_IN_W-1:0] xs_i   [SQ_R_W];
  logic [RM_W-1:0]    acc    [SQ_R_W];
  logic [RM_W-1:0]    trial  [SQ_R_W];
  logic [SQ_R_W-1:0]  ge;

  always_comb begin
    for (int i = 0; i < SQ_R_W; i++) begin
      if (i == 0) begin
        rem_i[i]  = '0;
        root_i[i] = '0;
        xs_i[i]   = x;
      end else begin
        rem_i[i]  = rem_q[i-1];
        root_i[i] = root_q[i-1];
        xs_i[i]   = xs_q[i-1];
      end
      acc[i]   = {rem_i[i], xs_i[i][SQ_IN_W-1 -: 2]};
      trial[i] = {root_i[i], 2'b01};
      ge[i]    = acc[i] >= trial[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SQ_R_W; i++) begin
        rem_q[i]  <= ge[i] ? SQ_R_W'(acc[i] - trial[i]) : SQ_R_W'(acc[i]);
        root_q[i] <= {root_i[i][SQ_R_W-2:0], ge[i]};
        xs_q[i]   <= xs_i[i] << 2;
      end
    end
  end

  assign root = root_q[SQ_R_W-1];

endmodule

[hw/rtl/awfn_div.sv]
module awfn_div import awfn_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  logic [DEN_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0]   nb_q  [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   q_q   [Q_W];

  logic [DEN_W-1:0] rem_i [Q_W];
  logic [Q_W-1:0]   nb_i  [Q_W];
  logic [DEN_W-1:0] den_i [Q_W];
  logic [Q_W-1:0]   q_i   [Q_W];
  logic [DEN_W:0]   acc   [Q_W];
  logic [Q_W-1:0]   ge;

  always_comb begin
    for (int i = 0; i < Q_W; i++) begin
      if (i == 0) begin
        rem_i[i] = DEN_W'(num[NUM_W-1:Q_W]);
        nb_i[i]  = num[Q_W-1:0];
        den_i[i] = den;
        q_i[i]   = '0;
      end else begin
        rem_i[i] = rem_q[i-1];
        nb_i[i]  = nb_q[i-1];
        den_i[i] = den_q[i-1];
        q_i[i]   = q_q[i-1];
      end
      acc[i] = {rem_i[i], nb_i[i][Q_W-1]};
      ge[i]  = acc[i] >= {1'b0, den_i[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Q_W; i++) begin
        rem_q[i] <= ge[i] ? DEN_W'(acc[i] - {1'b0, den_i[i]}) : DEN_W'(acc[i]);
        nb_q[i]  <= nb_i[i] << 1;
        den_q[i] <= den_i[i];
        q_q[i]   <= {q_i[i][Q_W-2:0], ge[i]};
      end
    end
  end

  assign quo = q_q[Q_W-1];

endmodule

[hw/rtl/awfn_back.sv]
module awfn_back import awfn_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  div_side_t              side,
  input  logic [2:0][Q_W-1:0]    quo,
  output logic                   out_valid,
  output logic signed [OUT_W-1:0] norm_x,
  output logic signed [OUT_W-1:0] norm_y,
  output logic signed [OUT_W-1:0] norm_z,
  output logic                   degenerate
);

  localparam logic [RX_W-1:0] POS_MAX = RX_W'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [RX_W-1:0] NEG_MAX = RX_W'(64'd1 << (OUT_W - 1));
  localparam logic [PR_W:0]   ROUND   = (PR_W+1)'(64'd1 << 29);

  function automatic logic [OUT_W-1:0] fin(input logic [PR_W-1:0] h, input logic [PR_W-1:0] l,
                                           input logic n);
    logic [PR_W:0]   p;
    logic [RX_W-1:0] r;
    p = ((PR_W+1)'(h) << AL_W) + (PR_W+1)'(l) + ROUND;
    r = RX_W'(p[PR_W:30]);
    if (n) begin
      if (r > NEG_MAX) r = NEG_MAX;
      r = -r;
    end else if (r > POS_MAX) begin
      r = POS_MAX;
    end
    return r[OUT_W-1:0];
  endfunction

  logic vld1;
  div_side_t side1;
  logic [PR_W-1:0] ph [3];
  logic [PR_W-1:0] pl [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld1      <= in_vld;
      out_valid <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= side;
      for (int k = 0; k < 3; k++) begin
        ph[k] <= PR_W'((Q_W+AH_W)'(quo[k]) * (Q_W+AH_W)'(side.area[A_W-1:AL_W]));
        pl[k] <= PR_W'((Q_W+AL_W)'(quo[k]) * (Q_W+AL_W)'(side.area[AL_W-1:0]));
      end
      degenerate <= side1.degen;
      norm_x <= side1.degen ? '0 : fin(ph[0], pl[0], side1.neg[0]);
      norm_y <= side1.degen ? '0 : fin(ph[1], pl[1], side1.neg[1]);
      norm_z <= side1.degen ? '0 : fin(ph[2], pl[2], side1.neg[2]);
    end
  end

endmodule

[verif/area_weighted_face_normal_tb.sv]
module area_weighted_face_normal_tb;
  import awfn_pkg::*;

  typedef longint vec3_t [3];
  typedef struct {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
    logic             degen;
  } normal_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic             mode;
  logic [POS_W-1:0] ori_p0, ori_p1, ori_p2, cur_p0, cur_p1, cur_p2;
  logic             out_valid;
  logic             out_stall;
  logic signed [OUT_W-1:0] norm_x, norm_y, norm_z;
  logic             degenerate;

  normal_t pending_normals[$];
  int      errors;
  int      quiet_cycles;
  bit      calm;

  area_weighted_face_normal u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .ori_p0(ori_p0), .ori_p1(ori_p1), .ori_p2(ori_p2),
    .cur_p0(cur_p0), .cur_p1(cur_p1), .cur_p2(cur_p2),
    .out_valid(out_valid), .out_stall(out_stall),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z), .degenerate(degenerate)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint coord_of(logic [POS_W-1:0] p, int k);
    logic signed [COORD_BITS-1:0] v;
    v = p[k*COORD_BITS +: COORD_BITS];
    return longint'(v);
  endfunction

  function automatic vec3_t edge_cross(logic [POS_W-1:0] a, logic [POS_W-1:0] b,
                                       logic [POS_W-1:0] c);
    longint e [3];
    longint f [3];
    vec3_t  r;
    for (int k = 0; k < 3; k++) begin
      e[k] = coord_of(b, k) - coord_of(a, k);
      f[k] = coord_of(c, k) - coord_of(b, k);
    end
    r[0] = e[1] * f[2] - e[2] * f[1];
    r[1] = e[2] * f[0] - e[0] * f[2];
    r[2] = e[0] * f[1] - e[1] * f[0];
    return r;
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= v) r = c;
    end
    return r;
  endfunction

  function automatic normal_t weighted_normal(logic md, logic [POS_W-1:0] o0,
      logic [POS_W-1:0] o1, logic [POS_W-1:0] o2, logic [POS_W-1:0] c0,
      logic [POS_W-1:0] c1, logic [POS_W-1:0] c2);
    vec3_t        cc;
    vec3_t        dd;
    logic [63:0]  dm [3];
    logic [63:0]  am, m, n, area, nd, len, u, r;
    logic [127:0] nc, p;
    logic [OUT_W-1:0] o [3];
    int           t;
    normal_t      res;
    cc = edge_cross(c0, c1, c2);
    if (md) dd = cc;
    else dd = edge_cross(o0, o1, o2);
    if (dd[0] == 0 && dd[1] == 0 && dd[2] == 0) begin
      res = '{0, 0, 0, 1'b1};
      return res;
    end
    nc = 0;
    for (int k = 0; k < 3; k++) begin
      am = (cc[k] < 0) ? -cc[k] : cc[k];
      nc += {64'd0, am} * {64'd0, am};
    end
    t = 15 - 2 * FRAC_BITS;
    if (t >= 0) n = isqrt(nc << (2 * (t + 1)));
    else n = isqrt(nc) >> (-t - 1);
    area = (n + 1) >> 1;
    for (int k = 0; k < 3; k++) dm[k] = (dd[k] < 0) ? -dd[k] : dd[k];
    m = dm[0];
    if (dm[1] > m) m = dm[1];
    if (dm[2] > m) m = dm[2];
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int k = 0; k < 3; k++) dm[k] >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int k = 0; k < 3; k++) dm[k] <<= 1;
    end
    nd = dm[0] * dm[0] + dm[1] * dm[1] + dm[2] * dm[2];
    len = isqrt({64'd0, nd} << 2);
    if (len == 0) len = 1;
    for (int k = 0; k < 3; k++) begin
      u = ((dm[k] << 32) + len) / (2 * len);
      p = {64'd0, u} * {64'd0, area} + (128'd1 << 29);
      if (p[127:94] != 0) r = '1;
      else r = p[93:30];
      if (dd[k] < 0) begin
        if (r > (64'd1 << 39)) r = 64'd1 << 39;
        o[k] = -r[OUT_W-1:0];
      end else begin
        if (r > (64'd1 << 39) - 1) r = (64'd1 << 39) - 1;
        o[k] = r[OUT_W-1:0];
      end
    end
    res = '{o[0], o[1], o[2], 1'b0};
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // expectations are taken at acceptance
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      pending_normals.insert(pending_normals.size(),
                             weighted_normal(mode, ori_p0, ori_p1, ori_p2,
                                             cur_p0, cur_p1, cur_p2));
  end

  always @(posedge clk) begin
    normal_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_normals.size() == 0) begin
        report_mismatch("unexpected word", norm_x, '0);
      end else begin
        w = pending_normals.pop_front();
        if (norm_x !== w.x) report_mismatch("norm_x", norm_x, w.x);
        if (norm_y !== w.y) report_mismatch("norm_y", norm_y, w.y);
        if (norm_z !== w.z) report_mismatch("norm_z", norm_z, w.z);
        if (degenerate !== w.degen) report_mismatch("degenerate", degenerate, w.degen);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 29);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 3000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_triangle(logic md, logic [POS_W-1:0] o0, logic [POS_W-1:0] o1,
      logic [POS_W-1:0] o2, logic [POS_W-1:0] c0, logic [POS_W-1:0] c1,
      logic [POS_W-1:0] c2);
    if (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= md;
    ori_p0 <= o0; ori_p1 <= o1; ori_p2 <= o2;
    cur_p0 <= c0; cur_p1 <= c1; cur_p2 <= c2;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
  endtask

  task automatic wait_drained();
    forever begin
      @(negedge clk);
      if (pending_normals.size() == 0) break;
    end
  endtask

  function automatic logic [POS_W-1:0] pack3(int x, int y, int z);
    logic [COORD_BITS-1:0] a, b, c;
    a = COORD_BITS'(x); b = COORD_BITS'(y); c = COORD_BITS'(z);
    return {c, b, a};
  endfunction

  function automatic logic [POS_W-1:0] rand_pos(int span);
    if (span == 0) return POS_W'({$urandom, $urandom});
    return pack3($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                 $urandom_range(2 * span) - span);
  endfunction

  task automatic test_directed();
    logic [POS_W-1:0] z, mx, mn, ex, ey;
    z  = '0;
    mx = pack3(32767, 32767, 32767);
    mn = pack3(-32768, -32768, -32768);
    ex = pack3(256, 0, 0);
    ey = pack3(0, 256, 0);
    // all zero, both modes
    send_triangle(1'b0, z, z, z, z, z, z);
    send_triangle(1'b1, z, z, z, z, z, z);
    // unit right triangle
    send_triangle(1'b0, z, ex, ey, z, ex, ey);
    send_triangle(1'b1, z, ex, ey, z, ey, ex);
    // zero current area with a nonzero direction
    send_triangle(1'b0, z, ex, ey, z, z, z);
    // current nonzero, original collinear
    send_triangle(1'b0, z, ex, pack3(512, 0, 0), z, ex, ey);
    send_triangle(1'b1, z, ex, pack3(512, 0, 0), z, ex, ey);
    // coordinate extremes
    send_triangle(1'b0, mn, pack3(32767, -32768, -32768), pack3(-32768, 32767, 32767),
                  mn, pack3(32767, -32768, -32768), pack3(-32768, 32767, 32767));
    send_triangle(1'b1, mx, pack3(-32768, 32767, 32767), pack3(32767, -32768, 32767),
                  mx, pack3(-32768, 32767, -32768), pack3(32767, -32768, 32767));
    send_triangle(1'b1, mn, pack3(32767, -32768, 0), pack3(0, 32767, -32768),
                  pack3(-32768, 0, 0), pack3(32767, 0, 0), pack3(-32768, 32767, 32767));
    send_triangle(1'b0, '1, '0, pack3(32767, 0, -32768), '0, '1, pack3(-32768, 32767, 0));
    send_triangle(1'b1, '1, '0, pack3(-32768, 0, 32767), pack3(0, -32768, 32767), '1, '0);
    // tiny triangles, the first with a huge original
    send_triangle(1'b0, mn, mx, pack3(32767, -32768, 0), z, pack3(1, 0, 0),
                  pack3(0, 1, 0));
    send_triangle(1'b1, z, z, z, z, pack3(1, 0, 0), pack3(0, 0, 1));
    send_triangle(1'b1, z, z, z, z, pack3(-1, 0, 0), pack3(0, -1, 0));
    in_valid <= 1'b0;
  endtask

  task automatic send_random(int n);
    logic [POS_W-1:0] p [6];
    int span, sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(9);
      span = (sel < 3) ? 0 : (sel < 6) ? 32767 : (sel < 8) ? 300 : 4;
      for (int k = 0; k < 6; k++) p[k] = rand_pos(span);
      // collinear current or original sets now and then
      if ($urandom_range(15) == 0) p[5] = p[4];
      if ($urandom_range(15) == 0) p[2] = p[1];
      send_triangle(1'($urandom_range(1)), p[0], p[1], p[2], p[3], p[4], p[5]);
    end
    in_valid <= 1'b0;
  endtask

  task automatic test_random_stream();
    calm = 1'b0;
    send_random(1000);
  endtask

  task automatic test_no_idling();
    calm = 1'b1;
    send_random(400);
    calm = 1'b0;
  endtask

  task automatic test_drain_pause();
    send_random(200);
    wait_drained();
    send_random(250);
  endtask

  initial begin
    errors = 0;
    calm = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    mode <= 1'b0;
    ori_p0 <= '0; ori_p1 <= '0; ori_p2 <= '0;
    cur_p0 <= '0; cur_p1 <= '0; cur_p2 <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_stream();
    test_no_idling();
    test_drain_pause();
    wait_drained();
    repeat (120) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
